/* rtl/btok_pkg.sv */
`default_nettype none

package btok_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int KW_COUNT    = 36;
  localparam int KW_MAX_LEN  = 9;
  localparam int KW_IDX_BITS = 6;

  localparam int RQ_DEPTH    = 4;
  localparam int RQ_PTR_BITS = 2;
  localparam int RQ_CNT_BITS = 3;

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_KEYWORD = 3'd2,
    KIND_SLASH   = 3'd3,
    KIND_EOF     = 3'd4,
    KIND_UNKNOWN = 3'd5
  } token_kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       final_byte;
  } byte_in_t;

  typedef struct packed {
    token_kind_e              token_kind;
    logic [KW_IDX_BITS-1:0]   keyword_index;
    logic [OFFSET_BITS-1:0]   start_offset;
    logic [LENGTH_BITS-1:0]   token_length;
    logic                     run_end;
  } token_out_t;

  // Up to two results are written into the result queue per accepted byte.
  typedef struct packed {
    logic [1:0]       count;
    token_out_t [1:0] slot;
  } rq_push_t;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // Keyword text, right-justified in the word; the first character is the
  // most significant of the used bytes.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "v", "vt", "vn", "f", "o", "g",
    "usemtl", "mtllib", "s", "l", "p",
    "newmtl", "Ka", "Kd", "Ks", "Ke", "Ns",
    "Ni", "d", "Tr", "Tf", "illum",
    "sharpness", "map_Kd", "map_Ka", "map_Ks",
    "map_Ke", "map_Ns", "map_d", "map_Tr",
    {"map_", "bump"}, "bump", {"map_", "refl"}, "refl",
    "disp", "decal"
  };

  localparam int KW_LEN [KW_COUNT] = '{
    1, 2, 2, 1, 1, 1,
    6, 6, 1, 1, 1,
    6, 2, 2, 2, 2, 2,
    2, 1, 2, 2, 5,
    9, 6, 6, 6,
    6, 6, 5, 6,
    8, 4, 8, 4,
    4, 5
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return is_alnum(c) || (c inside {CH_UNDER, CH_DOT, CH_BSLASH, CH_QUOTE, CH_COLON});
  endfunction

  function automatic logic is_ident_cont(input logic [7:0] c);
    return is_ident_start(c) || (c inside {CH_SLASH, CH_MINUS});
  endfunction

  function automatic logic is_number_cont(input logic [7:0] c);
    return is_digit(c) || (c inside {CH_DOT, CH_MINUS});
  endfunction

  // Advances the per-keyword match vector by one token byte at position cnt.
  function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] m,
                                                  input logic [LENGTH_BITS-1:0] cnt,
                                                  input logic [7:0] c);
    logic [KW_COUNT-1:0]     r;
    logic                    hit;
    logic [8*KW_MAX_LEN-1:0] text;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit  = 1'b0;
      text = KW_TEXT[i] << (8 * (KW_MAX_LEN - KW_LEN[i]));
      for (int k = 0; k < KW_MAX_LEN; k++) begin
        if (k < KW_LEN[i] && cnt == LENGTH_BITS'(k) &&
            text[8*(KW_MAX_LEN-1-k) +: 8] == c) begin
          hit = 1'b1;
        end
      end
      r[i] = m[i] && hit;
    end
    return r;
  endfunction

  // Builds the result for a token that is being closed.
  function automatic token_out_t make_token(input logic is_num,
                                            input logic [OFFSET_BITS-1:0] start,
                                            input logic [LENGTH_BITS-1:0] cnt,
                                            input logic [KW_COUNT-1:0] m);
    token_out_t t;
    t.token_kind    = is_num ? KIND_NUMBER : KIND_IDENT;
    t.keyword_index = '0;
    t.start_offset  = start;
    t.token_length  = cnt;
    t.run_end       = 1'b0;
    if (!is_num) begin
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
        if (m[i] && cnt == LENGTH_BITS'(KW_LEN[i])) begin
          t.token_kind    = KIND_KEYWORD;
          t.keyword_index = KW_IDX_BITS'(i);
        end
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* rtl/obj_mtl_byte_tokenizer.sv */
// Byte-stream tokenizer for OBJ and MTL text.
// Input channel: one source byte per beat, with a flag on the last byte of a
// source. Output channel: one token per beat (kind, keyword index, start
// offset, length, and a run_end flag on the last token caused by a byte).
// A byte yields zero, one or two tokens.
// Each accepted byte is classified and the scanner state updated in the same
// cycle; the resulting tokens are written into a four-entry result queue, so
// a token reaches the output only from the registered queue, never directly.
// The block takes one byte per cycle as long as the queue has two free entries;
// unstalled, the queue drains one token per cycle, so a steady stream of bytes
// each giving at most one token runs at full rate even with a token waiting.
// When the receiver stalls, tokens stay in the queue and input stall rises
// once fewer than two entries are free.
// Reset empties the queue and returns the scanner to whitespace skipping at
// offset zero. After a final byte the scanner returns to the same state, so
// the next byte starts a new source.
// Keywords are matched incrementally: one match bit per keyword is narrowed
// by each token byte, and the surviving bit with the right length wins.
`default_nettype none

module obj_mtl_byte_tokenizer import btok_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire byte_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output token_out_t    out_data_o
);

  typedef enum logic [1:0] {
    MODE_SKIP    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_IDENT   = 2'd3
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_inc;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [KW_COUNT-1:0]    match_q, match_d;

  logic        in_fire;
  logic        space;
  logic [7:0]  c;
  logic        handled, skipped;
  logic        v_a, v_b, v_c, v_d;
  token_kind_e kind_b;
  token_out_t  tok_a, tok_b, tok_c, tok_d, tok_x;
  rq_push_t    push;

  assign in_stall_o = !space;
  assign in_fire    = in_valid_i && space;

  always_comb begin
    c       = in_data_i.char_byte;
    mode_d  = mode_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    match_d = match_q;
    handled = 1'b0;
    skipped = 1'b0;
    v_a     = 1'b0;
    v_b     = 1'b0;
    v_c     = 1'b0;
    v_d     = 1'b0;
    kind_b  = KIND_SLASH;
    cnt_inc = (cnt_q == '1) ? cnt_q : LENGTH_BITS'(cnt_q + 1'b1);
    pos_inc = OFFSET_BITS'(pos_q + 1'b1);
    tok_a   = make_token(mode_q == MODE_NUMBER, start_q, cnt_q, match_q);

    case (mode_q)
      MODE_NUMBER: begin
        if (is_number_cont(c)) begin
          cnt_d   = cnt_inc;
          match_d = kw_step(match_q, cnt_q, c);
          handled = 1'b1;
        end else begin
          v_a    = 1'b1;
          mode_d = MODE_SKIP;
        end
      end
      MODE_IDENT: begin
        if (is_ident_cont(c)) begin
          cnt_d   = cnt_inc;
          match_d = kw_step(match_q, cnt_q, c);
          handled = 1'b1;
        end else begin
          v_a    = 1'b1;
          mode_d = MODE_SKIP;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          mode_d = MODE_SKIP;
        end
        skipped = 1'b1;
        handled = 1'b1;
      end
      default: ;
    endcase

    // A byte that closed a token is scanned again as if from whitespace.
    if (!handled) begin
      if (is_space(c)) begin
        skipped = 1'b1;
      end else if (c == CH_HASH) begin
        mode_d  = MODE_COMMENT;
        skipped = 1'b1;
      end else if (c == CH_SLASH) begin
        v_b    = 1'b1;
        kind_b = KIND_SLASH;
      end else if (c == CH_MINUS || is_digit(c)) begin
        mode_d  = MODE_NUMBER;
        start_d = pos_q;
        cnt_d   = LENGTH_BITS'(1);
        match_d = kw_step('1, '0, c);
      end else if (is_ident_start(c)) begin
        mode_d  = MODE_IDENT;
        start_d = pos_q;
        cnt_d   = LENGTH_BITS'(1);
        match_d = kw_step('1, '0, c);
      end else begin
        v_b    = 1'b1;
        kind_b = KIND_UNKNOWN;
      end
    end

    tok_c = make_token(mode_d == MODE_NUMBER, start_d, cnt_d, match_d);
    if (in_data_i.final_byte) begin
      if (mode_d == MODE_NUMBER || mode_d == MODE_IDENT) begin
        v_c = 1'b1;
      end else if (skipped) begin
        v_d = 1'b1;
      end
    end

    tok_b.token_kind    = kind_b;
    tok_b.keyword_index = '0;
    tok_b.start_offset  = pos_q;
    tok_b.token_length  = LENGTH_BITS'(1);
    tok_b.run_end       = 1'b1;

    tok_d.token_kind    = KIND_EOF;
    tok_d.keyword_index = '0;
    tok_d.start_offset  = pos_inc;
    tok_d.token_length  = '0;
    tok_d.run_end       = 1'b1;

    // At most one of the slash/unknown, final-token and end-of-file results
    // occurs, and it comes after the closed token whenever both occur.
    if (v_b) begin
      tok_x = tok_b;
    end else if (v_c) begin
      tok_x = tok_c;
    end else begin
      tok_x = tok_d;
    end
    tok_x.run_end = 1'b1;
    tok_a.run_end = !(v_b || v_c || v_d);

    push.slot[0] = v_a ? tok_a : tok_x;
    push.slot[1] = tok_x;
    push.count   = in_fire ? (2'(v_a) + 2'(v_b || v_c || v_d)) : 2'd0;

    pos_d = pos_inc;
    if (in_data_i.final_byte) begin
      mode_d  = MODE_SKIP;
      pos_d   = '0;
      start_d = '0;
      cnt_d   = '0;
      match_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SKIP;
      pos_q   <= '0;
      start_q <= '0;
      cnt_q   <= '0;
      match_q <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
    end
  end

  btok_rq u_rq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_open_token_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_NUMBER || mode_q == MODE_IDENT) |-> cnt_q != '0)
    else $error("open token with zero length");

  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.final_byte) |=> (mode_q == MODE_SKIP && pos_q == '0))
    else $error("scanner not returned to start after final byte");

  a_offset_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_data_i.final_byte) |=>
      pos_q == OFFSET_BITS'($past(pos_q) + 1'b1))
    else $error("byte offset did not advance by one");

  a_no_push_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |-> push.count == 2'd0)
    else $error("result written without an accepted byte");

endmodule

`default_nettype wire

/* rtl/btok_rq.sv */
`default_nettype none

module btok_rq import btok_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rq_push_t   push_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output token_out_t      out_data_o
);

  token_out_t             mem_q [RQ_DEPTH];
  logic [RQ_PTR_BITS-1:0] wr_q, wr_d;
  logic [RQ_PTR_BITS-1:0] rd_q, rd_d;
  logic [RQ_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // A new byte may bring two results, so room for two is required.
  assign space_o     = (cnt_q <= RQ_CNT_BITS'(RQ_DEPTH - 2));

  always_comb begin
    wr_d  = RQ_PTR_BITS'(wr_q + RQ_PTR_BITS'(push_i.count));
    rd_d  = pop ? RQ_PTR_BITS'(rd_q + 1'b1) : rd_q;
    cnt_d = RQ_CNT_BITS'(cnt_q + RQ_CNT_BITS'(push_i.count) - RQ_CNT_BITS'(pop));
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.slot[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[RQ_PTR_BITS'(wr_q + 1'b1)] <= push_i.slot[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* tb/obj_mtl_byte_tokenizer_tb.sv */
`timescale 1ns / 100ps

module obj_mtl_byte_tokenizer_tb;
  import btok_pkg::*;

  localparam int PRED = -1;

  typedef enum logic [1:0] {
    LEX_SKIP,
    LEX_COMMENT,
    LEX_NUMBER,
    LEX_IDENT
  } lex_mode_e;

  typedef struct {
    logic [7:0]  c;
    logic        fin;
    int          n;
    token_kind_e k0;
    int          i0;
    int          o0;
    int          l0;
    token_kind_e k1;
    int          o1;
    int          l1;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  byte_in_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  token_out_t out_data_o;

  obj_mtl_byte_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  string kw_words [36] = '{
    "v", "vt", "vn", "f", "o", "g", "usemtl", "mtllib", "s", "l", "p",
    "newmtl", "Ka", "Kd", "Ks", "Ke", "Ns", "Ni", "d", "Tr", "Tf", "illum",
    "sharpness", "map_Kd", "map_Ka", "map_Ks", "map_Ke", "map_Ns", "map_d",
    "map_Tr", {"map_", "bump"}, "bump", {"map_", "refl"}, "refl", "disp", "decal"
  };

  string head_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.\\':";
  string body_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.\\':/-";

  // Directed source: starts right after reset, so offsets count from zero.
  dir_row_t dir_rows [27] = '{
    '{8'h2F, 1'b0, 1, KIND_SLASH,   0,  0, 1, KIND_NUMBER, 0, 0},
    '{8'hFF, 1'b0, 1, KIND_UNKNOWN, 0,  1, 1, KIND_NUMBER, 0, 0},
    '{8'h00, 1'b0, 1, KIND_UNKNOWN, 0,  2, 1, KIND_NUMBER, 0, 0},
    '{"v",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{" ",   1'b0, 1, KIND_KEYWORD, 0,  3, 1, KIND_NUMBER, 0, 0},
    '{"-",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"9",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"/",   1'b0, 2, KIND_NUMBER,  0,  5, 2, KIND_SLASH,  7, 1},
    '{"#",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{8'hFF, 1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{8'h0A, 1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"m",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"a",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"p",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"_",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"K",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"s",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{8'h09, 1'b0, 1, KIND_KEYWORD, 25, 11, 6, KIND_NUMBER, 0, 0},
    '{"_",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"7",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{8'h80, 1'b0, 2, KIND_IDENT,   0, 18, 2, KIND_UNKNOWN, 20, 1},
    '{"x",   1'b1, 1, KIND_IDENT,   0, 21, 1, KIND_NUMBER, 0, 0},
    '{" ",   1'b1, 1, KIND_EOF,     0,  1, 0, KIND_NUMBER, 0, 0},
    '{"0",   1'b0, PRED, KIND_NUMBER, 0, 0, 0, KIND_NUMBER, 0, 0},
    '{"-",   1'b1, 1, KIND_NUMBER,  0,  0, 2, KIND_NUMBER, 0, 0},
    '{"/",   1'b1, 1, KIND_SLASH,   0,  0, 1, KIND_NUMBER, 0, 0},
    '{8'h7F, 1'b1, 1, KIND_UNKNOWN, 0,  0, 1, KIND_NUMBER, 0, 0}
  };

  // Scanner copy kept by the testbench.
  lex_mode_e   lex_mode;
  logic [31:0] lex_pos;
  logic [31:0] lex_start;
  logic [15:0] lex_len;
  logic [7:0]  lex_head [9];

  token_out_t  fresh_tokens [$];
  token_out_t  pending_tokens [$];
  token_out_t  typed_tok [2];
  int          typed_n = PRED;
  token_out_t  want;
  int          errors = 0;
  int          bytes_sent = 0;
  int          in_idle_pct = 0;
  bit          calm = 1'b0;

  function automatic logic char_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_word_head(input logic [7:0] c);
    return char_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "_" || c == "." || c == "\\" || c == "'" || c == ":";
  endfunction

  function automatic token_out_t make_tok(input token_kind_e kind, input int kw,
                                          input int off, input int len,
                                          input logic last);
    token_out_t t;
    t.token_kind    = kind;
    t.keyword_index = KW_IDX_BITS'(kw);
    t.start_offset  = OFFSET_BITS'(off);
    t.token_length  = LENGTH_BITS'(len);
    t.run_end       = last;
    return t;
  endfunction

  function automatic void fresh_add(input token_out_t t);
    fresh_tokens = {fresh_tokens, t};
  endfunction

  function automatic void lex_clear();
    lex_mode  = LEX_SKIP;
    lex_pos   = '0;
    lex_start = '0;
    lex_len   = '0;
    for (int k = 0; k < 9; k++) lex_head[k] = '0;
  endfunction

  function automatic void lex_grow(input logic [7:0] c);
    if (lex_len < 16'd9) lex_head[lex_len] = c;
    if (lex_len != 16'hFFFF) lex_len++;
  endfunction

  function automatic void lex_open(input lex_mode_e m, input logic [7:0] c,
                                   input logic [31:0] pos);
    lex_mode  = m;
    lex_start = pos;
    lex_len   = '0;
    lex_grow(c);
  endfunction

  // Emits the number or identifier that is open; identifiers are looked up
  // by exact length and text.
  function automatic void lex_close();
    int  hit;
    bit  same;
    hit = -1;
    if (lex_mode == LEX_IDENT) begin
      for (int i = 0; i < 36 && hit < 0; i++) begin
        if (int'(lex_len) == kw_words[i].len()) begin
          same = 1'b1;
          for (int k = 0; k < kw_words[i].len(); k++) begin
            if (lex_head[k] != kw_words[i][k]) same = 1'b0;
          end
          if (same) hit = i;
        end
      end
    end
    if (lex_mode == LEX_NUMBER)
      fresh_add(make_tok(KIND_NUMBER, 0, lex_start, lex_len, 1'b0));
    else if (hit >= 0)
      fresh_add(make_tok(KIND_KEYWORD, hit, lex_start, lex_len, 1'b0));
    else
      fresh_add(make_tok(KIND_IDENT, 0, lex_start, lex_len, 1'b0));
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic fin);
    logic [31:0] pos;
    bit          handled;
    bit          skipped;
    token_out_t  t;
    pos     = lex_pos;
    handled = 1'b0;
    skipped = 1'b0;
    fresh_tokens.delete();
    case (lex_mode)
      LEX_NUMBER: begin
        if (char_digit(c) || c == "." || c == "-") begin
          lex_grow(c);
          handled = 1'b1;
        end else begin
          lex_close();
          lex_mode = LEX_SKIP;
        end
      end
      LEX_IDENT: begin
        if (char_word_head(c) || c == "/" || c == "-") begin
          lex_grow(c);
          handled = 1'b1;
        end else begin
          lex_close();
          lex_mode = LEX_SKIP;
        end
      end
      LEX_COMMENT: begin
        if (c == 8'h0A) lex_mode = LEX_SKIP;
        skipped = 1'b1;
        handled = 1'b1;
      end
      default: ;
    endcase
    if (!handled) begin
      if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
        skipped = 1'b1;
      end else if (c == "#") begin
        lex_mode = LEX_COMMENT;
        skipped  = 1'b1;
      end else if (c == "/") begin
        fresh_add(make_tok(KIND_SLASH, 0, pos, 1, 1'b0));
      end else if (c == "-" || char_digit(c)) begin
        lex_open(LEX_NUMBER, c, pos);
      end else if (char_word_head(c)) begin
        lex_open(LEX_IDENT, c, pos);
      end else begin
        fresh_add(make_tok(KIND_UNKNOWN, 0, pos, 1, 1'b0));
      end
    end
    lex_pos = pos + 32'd1;
    if (fin) begin
      if (lex_mode == LEX_NUMBER || lex_mode == LEX_IDENT)
        lex_close();
      else if (skipped)
        fresh_add(make_tok(KIND_EOF, 0, lex_pos, 0, 1'b0));
      lex_clear();
    end
    if (fresh_tokens.size() > 0) begin
      t = fresh_tokens[fresh_tokens.size() - 1];
      t.run_end = 1'b1;
      fresh_tokens[fresh_tokens.size() - 1] = t;
    end
  endfunction

  // Both channels are observed here, input first, so a token can never be
  // looked up before the byte that causes it has been predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        lex_byte(in_data_i.char_byte, in_data_i.final_byte);
        if (typed_n >= 0) begin
          for (int j = 0; j < typed_n; j++) pending_tokens = {pending_tokens, typed_tok[j]};
        end else begin
          foreach (fresh_tokens[j]) pending_tokens = {pending_tokens, fresh_tokens[j]};
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_tokens.size() == 0) begin
          $error("token beat with nothing expected: kind %0d offset %0d",
                 out_data_o.token_kind, out_data_o.start_offset);
          errors++;
        end else begin
          want = pending_tokens.pop_front();
          if (out_data_o.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind,
                   out_data_o.token_kind);
            errors++;
          end
          if (out_data_o.keyword_index !== want.keyword_index) begin
            $error("keyword_index: expected %0d, got %0d", want.keyword_index,
                   out_data_o.keyword_index);
            errors++;
          end
          if (out_data_o.start_offset !== want.start_offset) begin
            $error("start_offset: expected %0d, got %0d", want.start_offset,
                   out_data_o.start_offset);
            errors++;
          end
          if (out_data_o.token_length !== want.token_length) begin
            $error("token_length: expected %0d, got %0d", want.token_length,
                   out_data_o.token_length);
            errors++;
          end
          if (out_data_o.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, out_data_o.run_end);
            errors++;
          end
        end
      end
    end
  end

  // Receiver back-pressure in bursts.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int       gap;
    byte_in_t b;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < in_idle_pct) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    b.char_byte  = c;
    b.final_byte = fin;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_rnd(input logic [7:0] c);
    send_byte(c, $urandom_range(0, 89) == 0);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_rnd(s[k]);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_rnd(8'($urandom_range(48, 57)));
  endtask

  task automatic send_number();
    if ($urandom_range(0, 2) == 0) send_rnd("-");
    send_digits($urandom_range(1, 4));
    if ($urandom_range(0, 1) == 0) begin
      send_rnd(".");
      send_digits($urandom_range(1, 4));
    end
    if ($urandom_range(0, 9) == 0) send_text("e-5");
  endtask

  task automatic send_ident(input int len);
    send_rnd(head_chars[$urandom_range(0, head_chars.len() - 1)]);
    repeat (len - 1) send_rnd(body_chars[$urandom_range(0, body_chars.len() - 1)]);
  endtask

  task automatic send_blank();
    send_rnd($urandom_range(0, 3) == 0 ? 8'h09 : 8'h20);
  endtask

  // One statement line: a keyword, a few arguments, and a line end.
  task automatic send_line();
    int    pick;
    string word;
    word = kw_words[$urandom_range(0, 35)];
    send_text(word);
    repeat ($urandom_range(1, 4)) begin
      send_blank();
      pick = $urandom_range(0, 5);
      if (pick < 2) begin
        send_number();
      end else if (pick < 4) begin
        send_digits($urandom_range(1, 3));
        send_rnd("/");
        if (pick == 2) send_digits($urandom_range(1, 3));
        send_rnd("/");
        send_digits($urandom_range(1, 3));
      end else begin
        send_ident($urandom_range(1, 12));
      end
    end
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      send_text(" # ");
      send_ident($urandom_range(1, 8));
    end else if (pick == 1) begin
      send_rnd(8'h0D);
    end
    send_rnd(8'h0A);
  endtask

  task automatic send_chunk();
    int    pick;
    string word;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_line();
    end else if (pick < 58) begin
      send_rnd("#");
      repeat ($urandom_range(0, 10)) send_rnd(8'($urandom_range(0, 255)));
      send_rnd(8'h0A);
    end else if (pick < 68) begin
      // Keywords that are cut short or run on must not match.
      word = kw_words[$urandom_range(0, 35)];
      if (word.len() > 1 && $urandom_range(0, 1) == 0)
        send_text(word.substr(0, word.len() - 2));
      else begin
        send_text(word);
        send_ident($urandom_range(1, 3));
      end
      send_blank();
    end else if (pick < 76) begin
      send_ident($urandom_range(1, 12));
      send_blank();
    end else if (pick < 84) begin
      send_number();
      send_blank();
    end else if (pick < 96) begin
      repeat ($urandom_range(1, 4)) send_rnd(8'($urandom_range(0, 255)));
    end else begin
      send_rnd($urandom_range(0, 5) == 0 ? 8'h20 : 8'($urandom_range(9, 13)));
    end
  endtask

  initial begin
    int base;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    for (int j = 0; j < 2; j++) typed_tok[j] = '0;
    lex_clear();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    in_idle_pct = 20;
    foreach (dir_rows[r]) begin
      typed_n      = dir_rows[r].n;
      typed_tok[0] = make_tok(dir_rows[r].k0, dir_rows[r].i0, dir_rows[r].o0,
                              dir_rows[r].l0, dir_rows[r].n == 1);
      typed_tok[1] = make_tok(dir_rows[r].k1, 0, dir_rows[r].o1, dir_rows[r].l1, 1'b1);
      send_byte(dir_rows[r].c, dir_rows[r].fin);
    end
    typed_n = PRED;

    base = bytes_sent;
    while (bytes_sent - base < 1030) begin
      if (bytes_sent - base > 880) calm = 1'b1;
      in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
      send_chunk();
    end

    calm = 1'b1;
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", pending_tokens.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
